/* hw/rtl/tlf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlf_pkg
// Shared types and constants of the text line filter: counter size,
// configuration register indexes and the word passed from front to back.
// ----------------------------------------------------------------------------
package tlf_pkg;

  localparam int NUMBER_DIGITS = 7;   // BCD line counter digits
  localparam int NUM_WIDTH     = 6;   // right-aligned field width of the number
  localparam int MAX_OUT       = 12;  // output words one input word may cause
  localparam int DIG_W         = $clog2(NUMBER_DIGITS);
  localparam int CNT_W         = $clog2(MAX_OUT);
  localparam int REND_MAX      = 4;   // rendered bytes of one input byte, at most

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOLL  = 8'h24;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  typedef enum logic [2:0] {
    REG_NUMBER_ALL       = 3'd0,
    REG_NUMBER_NONBLANK  = 3'd1,
    REG_SQUEEZE_BLANK    = 3'd2,
    REG_SHOW_ENDS        = 3'd3,
    REG_SHOW_TABS        = 3'd4,
    REG_SHOW_NONPRINTING = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic number_all;
    logic number_nonblank;
    logic squeeze_blank;
    logic show_ends;
    logic show_tabs;
    logic show_nonprinting;
  } cfg_t;

  typedef logic [NUMBER_DIGITS-1:0][3:0] bcd_t;

  // One classified input word, ready for the back end to expand.
  typedef struct packed {
    logic                         numbered;  // emit the line number first
    bcd_t                         bcd;       // number to print
    logic [DIG_W-1:0]             top;       // highest nonzero digit (0 if none)
    logic [REND_MAX-1:0][7:0]     rend;      // rendered bytes, first at index 0
    logic [1:0]                   rend_last; // index of the last rendered byte
  } item_t;

endpackage

/* hw/rtl/tlf_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlf_front
// Accepts input words, tracks line start, blank run and line counter, and
// classifies each byte into a queue entry. Squeezed lines push nothing.
// ----------------------------------------------------------------------------
module tlf_front
  import tlf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       q_full,
  output logic       q_push,
  output item_t      q_item
);

  logic       at_line_start_r, at_line_start_nxt;
  logic [1:0] blank_run_r, blank_run_nxt;
  bcd_t       bcd_r, bcd_nxt, bcd_inc;
  logic       accept, blank, squeezed, numbered;
  logic [DIG_W-1:0] top;
  logic [3:0] d;
  logic       carry;
  logic [7:0] c;

  assign c         = in_tdata;
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // BCD increment, ripple over the digits
  always_comb begin
    carry   = 1'b1;
    bcd_inc = '0;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      d = (bcd_r[i] > 4'd9) ? 4'd9 : bcd_r[i];
      d = d + {3'd0, carry};
      carry = (d > 4'd9);
      bcd_inc[i] = carry ? 4'd0 : d;
    end
  end

  always_comb begin
    top = '0;
    for (int i = 1; i < NUMBER_DIGITS; i++) begin
      if (bcd_r[i] != 4'd0) top = DIG_W'(i);
    end
  end

  always_comb begin
    blank         = (c == CH_NL);
    blank_run_nxt = blank_run_r;
    squeezed      = 1'b0;
    numbered      = 1'b0;
    if (at_line_start_r) begin
      if (!blank)                    blank_run_nxt = 2'd0;
      else if (blank_run_r != 2'd3)  blank_run_nxt = blank_run_r + 2'd1;
      squeezed = cfg.squeeze_blank && (blank_run_nxt > 2'd1);
      numbered = !squeezed && (cfg.number_all || (cfg.number_nonblank && !blank));
    end
    at_line_start_nxt = squeezed || blank;
    bcd_nxt           = numbered ? bcd_inc : bcd_r;
  end

  // rendering of the byte itself
  always_comb begin
    q_item.numbered  = numbered;
    q_item.bcd       = bcd_r;
    q_item.top       = top;
    q_item.rend      = '0;
    q_item.rend_last = 2'd0;
    if (cfg.show_tabs && c == CH_TAB) begin
      q_item.rend[0]   = CH_CARET;
      q_item.rend[1]   = CH_I;
      q_item.rend_last = 2'd1;
    end else if (cfg.show_ends && c == CH_NL) begin
      q_item.rend[0]   = CH_DOLL;
      q_item.rend[1]   = c;
      q_item.rend_last = 2'd1;
    end else if (cfg.show_nonprinting && c != CH_NL && c != CH_TAB) begin
      if (c < 8'h20) begin
        q_item.rend[0]   = CH_CARET;
        q_item.rend[1]   = c + 8'd64;
        q_item.rend_last = 2'd1;
      end else if (c == CH_DEL) begin
        q_item.rend[0]   = CH_CARET;
        q_item.rend[1]   = CH_QUEST;
        q_item.rend_last = 2'd1;
      end else if (c >= 8'h80 && c < 8'hA0) begin
        q_item.rend[0]   = CH_M;
        q_item.rend[1]   = CH_DASH;
        q_item.rend[2]   = CH_CARET;
        q_item.rend[3]   = c - 8'd64;
        q_item.rend_last = 2'd3;
      end else if (c >= 8'hA0 && c < 8'hFF) begin
        q_item.rend[0]   = CH_M;
        q_item.rend[1]   = CH_DASH;
        q_item.rend[2]   = c - 8'd128;
        q_item.rend_last = 2'd2;
      end else if (c == 8'hFF) begin
        q_item.rend[0]   = CH_M;
        q_item.rend[1]   = CH_DASH;
        q_item.rend[2]   = CH_CARET;
        q_item.rend[3]   = CH_QUEST;
        q_item.rend_last = 2'd3;
      end else begin
        q_item.rend[0] = c;
      end
    end else begin
      q_item.rend[0] = c;
    end
  end

  assign q_push = accept && !squeezed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_line_start_r <= 1'b1;
      blank_run_r     <= 2'd0;
      bcd_r           <= bcd_t'(1);
    end else if (accept) begin
      at_line_start_r <= at_line_start_nxt;
      blank_run_r     <= blank_run_nxt;
      bcd_r           <= bcd_nxt;
    end
  end

endmodule

/* hw/rtl/tlf_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlf_queue
// Two-entry queue of classified words between front and back end.
// ----------------------------------------------------------------------------
module tlf_queue
  import tlf_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  output logic  head_valid,
  output item_t head_item,
  input  logic  pop
);

  item_t      entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_item  = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop)      count_nxt = count_r + 2'd1;
    else if (!push && pop) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_nxt;
    end
  end

endmodule

/* hw/rtl/tlf_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlf_back
// Expands the queue head into output words, one per cycle unless out_tready is low:
// number field and tab if numbered, then rendered bytes; output is registered.
// ----------------------------------------------------------------------------
module tlf_back
  import tlf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  item_t      head_item,
  output logic       pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast
);

  typedef enum logic [1:0] {PH_START, PH_NUM, PH_TAB, PH_REND} phase_t;

  phase_t           phase_r, phase_nxt, eff_phase;
  logic [DIG_W-1:0] idx_r, idx_nxt, eff_idx;
  logic [CNT_W-1:0] cnt_r;
  logic             out_valid_r, out_last_r;
  logic [7:0]       out_data_r, byte_sel;
  logic [3:0]       digit;
  logic             done, step;

  always_comb begin
    eff_phase = phase_r;
    eff_idx   = idx_r;
    if (phase_r == PH_START) begin
      if (head_item.numbered) begin
        eff_phase = PH_NUM;
        eff_idx   = (head_item.top > DIG_W'(NUM_WIDTH - 1)) ? head_item.top
                                                            : DIG_W'(NUM_WIDTH - 1);
      end else begin
        eff_phase = PH_REND;
        eff_idx   = '0;
      end
    end
  end

  assign digit = (head_item.bcd[eff_idx] > 4'd9) ? 4'd9 : head_item.bcd[eff_idx];

  always_comb begin
    byte_sel  = head_item.rend[eff_idx[1:0]];
    phase_nxt = eff_phase;
    idx_nxt   = eff_idx;
    unique case (eff_phase)
      PH_NUM: begin
        byte_sel = (eff_idx > head_item.top) ? CH_SPACE : (CH_ZERO + {4'd0, digit});
        if (eff_idx == '0) phase_nxt = PH_TAB;
        else               idx_nxt   = eff_idx - 1'b1;
      end
      PH_TAB: begin
        byte_sel  = CH_TAB;
        phase_nxt = PH_REND;
        idx_nxt   = '0;
      end
      PH_REND: begin
        idx_nxt = eff_idx + 1'b1;
      end
      default: ;
    endcase
  end

  assign done = (eff_phase == PH_REND && eff_idx[1:0] == head_item.rend_last) ||
                (cnt_r == CNT_W'(MAX_OUT - 1));
  assign step = head_valid && (!out_valid_r || out_tready);
  assign pop  = step && done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      idx_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
      out_data_r  <= byte_sel;
      out_last_r  <= done;
      phase_r     <= done ? PH_START : phase_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= done ? '0 : cnt_r + 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

/* hw/rtl/text_line_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_line_filter
// Byte stream text filter: line numbering, blank line squeezing, visible
// tabs, line ends and non-printing bytes.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in_      slave      in_tvalid/in_tready    in_tdata[7:0] = in_byte
//  out_     master     out_tvalid/out_tready  out_tdata[7:0] = out_byte,
//                                             out_tlast = last_of_run
//  cfg_     slave      cfg_valid/cfg_ready    cfg_index[2:0], cfg_data (bit 0)
//
//  The back end sends the words of one input byte one after another, so a
//  byte that renders to n words (at most twelve) holds it until all are
//  sent; plain text moves at one word per cycle while out_tready is high.
//  The two-entry queue lets the front keep taking bytes while the back end
//  expands or out_tready is low. Squeezed blank lines give no output.
//  Reset (rst_n low, synchronous) is ready the next cycle; no clearing pass.
// ----------------------------------------------------------------------------
module text_line_filter
  import tlf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  // output stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,
  // configuration writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic       cfg_data
);

  cfg_t  cfg_r;
  logic  q_push, q_full, q_pop, q_head_valid;
  item_t q_push_item, q_head_item;

  // Config writes are always taken; unknown indexes fall through.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_NUMBER_ALL:       cfg_r.number_all       <= cfg_data;
        REG_NUMBER_NONBLANK:  cfg_r.number_nonblank  <= cfg_data;
        REG_SQUEEZE_BLANK:    cfg_r.squeeze_blank    <= cfg_data;
        REG_SHOW_ENDS:        cfg_r.show_ends        <= cfg_data;
        REG_SHOW_TABS:        cfg_r.show_tabs        <= cfg_data;
        REG_SHOW_NONPRINTING: cfg_r.show_nonprinting <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: line tracking, counter, byte classification
  tlf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_push_item)
  );

  tlf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_push_item),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head_item  (q_head_item),
    .pop        (q_pop)
  );

  // back: one output word per cycle from the queue head, while out_tready allows
  tlf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_item  (q_head_item),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

/* hw/rtl/tlf_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlf_checker
// Port-level checks of the text line filter, bound to the top level.
// ----------------------------------------------------------------------------
module tlf_checker
  import tlf_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  logic [CNT_W-1:0] run_cnt_r;

  // words of the current run already taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_cnt_r <= '0;
    end else if (out_tvalid && out_tready) begin
      run_cnt_r <= out_tlast ? '0 : run_cnt_r + 1'b1;
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output word changed");

  a_nl_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata == CH_NL |-> out_tlast)
    else $error("newline not at end of run");

  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && run_cnt_r == CNT_W'(MAX_OUT - 1) |-> out_tlast)
    else $error("run longer than limit");

endmodule

bind text_line_filter tlf_checker u_tlf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for text_line_filter. A table of directed bytes and
// register writes runs first. Six random phases follow, each with its own
// option setting. Every accepted byte goes through a behavioral formatter
// that keeps its own line-start, blank-run and BCD line counter state. Each
// output word is compared with the oldest expected word, data and tlast.
// ----------------------------------------------------------------------------
module testbench;
  import tlf_pkg::*;

  localparam int          SETTLE_CYCLES   = 16;   // drain time for words with no output
  localparam int          PHASES          = 6;
  localparam int          ITEMS_PER_PHASE = 17;
  localparam logic [2:0]  REG_SPARE_6     = 3'd6; // unused indexes, writes are ignored
  localparam logic [2:0]  REG_SPARE_7     = 3'd7;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       cfg_valid  = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index  = 3'd0;
  logic       cfg_data   = 1'b0;

  text_line_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Formatter state, mirrors the block's options, line tracking and counter
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [7:0] data;
    logic       last;
  } out_word_t;

  cfg_t       opts;
  logic       line_start;
  logic [1:0] blank_run;
  bcd_t       line_no;

  logic [7:0] rendered[$];      // words one input byte turns into
  out_word_t  pending_words[$]; // expected output words, oldest first
  string      typed_text = "";  // hand-written expectation for the current byte

  int errors      = 0;
  int bytes_in    = 0;
  int words_out   = 0;
  int reg_writes  = 0;
  int squeezed    = 0;
  int numbered    = 0;
  bit quiet       = 1'b0;        // no idling on either side

  function automatic void advance_line_no();
    logic [4:0] d;
    logic       carry;
    carry = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      d = (line_no[i] > 4'd9) ? 5'd9 : {1'b0, line_no[i]};
      d = d + carry;
      carry = (d > 5'd9);
      if (carry) d = 5'd0;
      line_no[i] = d[3:0];
    end
  endfunction

  // Builds the words for one input byte into rendered[] and updates state.
  function automatic void format_byte(logic [7:0] c);
    logic       blank;
    int         top;
    logic [7:0] r;
    rendered.delete();
    if (line_start) begin
      blank = (c == CH_NL);
      if (!blank) blank_run = 2'd0;
      else if (blank_run != 2'd3) blank_run = blank_run + 2'd1;
      // every blank line after the first of a run vanishes
      if (opts.squeeze_blank && blank_run > 2'd1) begin
        squeezed++;
        return;
      end
      if (opts.number_all || (opts.number_nonblank && !blank)) begin
        top = 0;
        for (int i = NUMBER_DIGITS - 1; i > 0; i--)
          if (top == 0 && line_no[i] != 4'd0) top = i;
        for (int i = NUM_WIDTH - 1; i > top; i--) rendered.push_back(CH_SPACE);
        for (int i = top; i >= 0; i--)
          rendered.push_back(CH_ZERO + ((line_no[i] > 4'd9) ? 8'd9 : {4'd0, line_no[i]}));
        rendered.push_back(CH_TAB);
        advance_line_no();
        numbered++;
      end
    end
    if (opts.show_tabs && c == CH_TAB) begin
      rendered.push_back(CH_CARET);
      rendered.push_back(CH_I);
    end else begin
      if (opts.show_ends && c == CH_NL) rendered.push_back(CH_DOLL);
      r = c;
      if (opts.show_nonprinting && c != CH_NL && c != CH_TAB) begin
        if (c < 8'h20) begin
          rendered.push_back(CH_CARET);
          r = c + 8'd64;
        end else if (c == CH_DEL) begin
          rendered.push_back(CH_CARET);
          r = CH_QUEST;
        end else if (c >= 8'h80 && c < 8'hA0) begin
          // 0x80 lands here as well and shows as M-^@
          rendered.push_back(CH_M);
          rendered.push_back(CH_DASH);
          rendered.push_back(CH_CARET);
          r = c - 8'd64;
        end else if (c >= 8'hA0 && c < 8'hFF) begin
          rendered.push_back(CH_M);
          rendered.push_back(CH_DASH);
          r = c - 8'd128;
        end else if (c == 8'hFF) begin
          rendered.push_back(CH_M);
          rendered.push_back(CH_DASH);
          rendered.push_back(CH_CARET);
          r = CH_QUEST;
        end
      end
      rendered.push_back(r);
    end
    line_start = (c == CH_NL);
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: one process sees config, input and output handshakes in a fixed
  // order, so an expectation is always queued before its words can show up.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    int        n;
    out_word_t w;
    if (!rst_n) begin
      opts       = '0;
      line_start = 1'b1;
      blank_run  = 2'd0;
      line_no    = bcd_t'(1);
    end else begin
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        case (cfg_index)
          REG_NUMBER_ALL:       opts.number_all       = cfg_data;
          REG_NUMBER_NONBLANK:  opts.number_nonblank  = cfg_data;
          REG_SQUEEZE_BLANK:    opts.squeeze_blank    = cfg_data;
          REG_SHOW_ENDS:        opts.show_ends        = cfg_data;
          REG_SHOW_TABS:        opts.show_tabs        = cfg_data;
          REG_SHOW_NONPRINTING: opts.show_nonprinting = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        bytes_in++;
        format_byte(in_tdata);
        // a typed row overrides the formatter's words, state still advances
        if (typed_text.len() != 0) begin
          rendered.delete();
          for (int i = 0; i < typed_text.len(); i++) rendered.push_back(typed_text[i]);
        end
        n = (rendered.size() > MAX_OUT) ? MAX_OUT : rendered.size();
        for (int i = 0; i < n; i++) begin
          w.data = rendered[i];
          w.last = (i == n - 1);
          pending_words.push_back(w);
        end
      end
      if (out_tvalid && out_tready) begin
        words_out++;
        if (pending_words.size() == 0) begin
          errors++;
          $display("%0t: output word with nothing expected: data %h last %b",
                   $time, out_tdata, out_tlast);
        end else begin
          w = pending_words.pop_front();
          if (out_tdata !== w.data) begin
            errors++;
            $display("%0t: out_tdata expected %h actual %h", $time, w.data, out_tdata);
          end
          if (out_tlast !== w.last) begin
            errors++;
            $display("%0t: out_tlast expected %b actual %b", $time, w.last, out_tlast);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, with calm stretches in between
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  int calm_left  = 0;

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (quiet || calm_left > 0) begin
      out_tready <= 1'b1;
      if (calm_left > 0) calm_left--;
    end else if ($urandom_range(0, 4) == 0) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(1, 6) - 1;
      if ($urandom_range(0, 2) == 0) calm_left = $urandom_range(10, 40);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender tasks, all entered and left at a falling edge
  // ---------------------------------------------------------------------------

  // Lowers valid, waits for every expected word, then gives squeezed lines
  // still in the pipe time to retire.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b, input string typed);
    typed_text = typed;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  typedef struct {
    logic       is_write;
    logic [2:0] index;
    logic       value;
    logic [7:0] data;
    string      typed;   // empty: expectation comes from the formatter
  } step_t;

  step_t steps[$];

  function automatic step_t reg_row(logic [2:0] idx, logic value);
    step_t s;
    s.is_write = 1'b1;
    s.index    = idx;
    s.value    = value;
    s.data     = 8'h00;
    s.typed    = "";
    return s;
  endfunction

  function automatic step_t byte_row(logic [7:0] b, string typed);
    step_t s;
    s.is_write = 1'b0;
    s.index    = 3'd0;
    s.value    = 1'b0;
    s.data     = b;
    s.typed    = typed;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    cfg_t pick;
    int   sent;
    int   roll;
    bit   paused;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // options at reset: bytes pass through untouched
    steps.push_back(byte_row(8'h41, "A"));
    steps.push_back(byte_row(8'h00, ""));
    steps.push_back(byte_row(8'hFF, ""));
    steps.push_back(byte_row(CH_NL, "\n"));
    // all visible, every line numbered
    steps.push_back(reg_row(REG_NUMBER_ALL, 1'b1));
    steps.push_back(reg_row(REG_SHOW_ENDS, 1'b1));
    steps.push_back(reg_row(REG_SHOW_TABS, 1'b1));
    steps.push_back(reg_row(REG_SHOW_NONPRINTING, 1'b1));
    steps.push_back(byte_row(8'h78, "     1\tx"));
    steps.push_back(byte_row(CH_TAB, "^I"));
    steps.push_back(byte_row(8'h80, "M-^@"));
    steps.push_back(byte_row(8'hFF, "M-^?"));
    steps.push_back(byte_row(CH_DEL, "^?"));
    steps.push_back(byte_row(8'h01, "^A"));
    steps.push_back(byte_row(8'hA0, "M- "));
    steps.push_back(byte_row(8'hFE, "M-~"));
    steps.push_back(byte_row(8'h9F, "M-^_"));
    steps.push_back(byte_row(CH_NL, "$\n"));
    steps.push_back(byte_row(CH_NL, "     2\t$\n"));   // blank line still numbered
    steps.push_back(byte_row(8'h80, "     3\tM-^@"));  // longest expansion here
    steps.push_back(byte_row(CH_NL, "$\n"));
    // number non-blank lines only, squeeze blank runs, plain rendering
    steps.push_back(reg_row(REG_NUMBER_ALL, 1'b0));
    steps.push_back(reg_row(REG_NUMBER_NONBLANK, 1'b1));
    steps.push_back(reg_row(REG_SQUEEZE_BLANK, 1'b1));
    steps.push_back(reg_row(REG_SHOW_ENDS, 1'b0));
    steps.push_back(reg_row(REG_SHOW_TABS, 1'b0));
    steps.push_back(reg_row(REG_SHOW_NONPRINTING, 1'b0));
    steps.push_back(byte_row(CH_NL, "\n"));
    steps.push_back(byte_row(CH_NL, ""));               // squeezed, no words
    steps.push_back(byte_row(CH_NL, ""));               // blank run saturates
    steps.push_back(byte_row(8'h62, "     4\tb"));
    steps.push_back(byte_row(CH_NL, "\n"));
    // unused indexes change nothing; then both numbering flags on
    steps.push_back(reg_row(REG_SPARE_6, 1'b1));
    steps.push_back(reg_row(REG_SPARE_7, 1'b1));
    steps.push_back(reg_row(REG_NUMBER_ALL, 1'b1));
    steps.push_back(byte_row(CH_NL, "     5\t\n"));
    steps.push_back(byte_row(CH_NL, ""));
    steps.push_back(byte_row(8'h7A, "     6\tz"));

    foreach (steps[k]) begin
      if (steps[k].is_write) write_reg(steps[k].index, steps[k].value);
      else send_byte(steps[k].data, steps[k].typed);
    end

    // Random phases: first all options on, then all off, then random mixes.
    // Mostly lines of printable text with newline runs, plus raw noise.
    paused = 1'b0;
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) pick = '1;
      else if (phase == 1) pick = '0;
      else pick = cfg_t'(6'($urandom_range(0, 63)));
      quiet = (phase == PHASES - 1);
      write_reg(REG_NUMBER_ALL, pick.number_all);
      write_reg(REG_NUMBER_NONBLANK, pick.number_nonblank);
      write_reg(REG_SQUEEZE_BLANK, pick.squeeze_blank);
      write_reg(REG_SHOW_ENDS, pick.show_ends);
      write_reg(REG_SHOW_TABS, pick.show_tabs);
      write_reg(REG_SHOW_NONPRINTING, pick.show_nonprinting);
      if ($urandom_range(0, 2) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_7 : REG_SPARE_6,
                  1'($urandom_range(0, 1)));

      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
          repeat ($urandom_range(1, 4)) begin
            send_byte(CH_NL, "");
            sent++;
          end
        end else if (roll < 22) begin
          send_byte(CH_TAB, "");
          sent++;
        end else if (roll < 32) begin
          send_byte(8'($urandom_range(0, 255)), "");
          sent++;
        end else if (roll < 40) begin
          send_byte(8'($urandom_range(8'h80, 8'hFF)), "");
          sent++;
        end else begin
          send_byte(8'($urandom_range(8'h20, 8'h7E)), "");
          sent++;
        end
        // hold the sender once until the block has caught up completely
        if (phase == 2 && !paused && sent >= 10) begin
          paused = 1'b1;
          wait_idle();
        end
      end
    end

    wait_idle();
    $display("covered %0d bytes in, %0d words out, %0d register writes",
             bytes_in, words_out, reg_writes);
    $display("%0d lines numbered, %0d blank lines squeezed", numbered, squeezed);
    if (errors == 0 && pending_words.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("%0t: timeout, %0d words still expected", $time, pending_words.size());
    $display("testbench: errors");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/tlf_pkg.sv
hw/rtl/tlf_front.sv
hw/rtl/tlf_queue.sv
hw/rtl/tlf_back.sv
hw/rtl/text_line_filter.sv
hw/rtl/tlf_checker.sv
tb/testbench.sv
